>>> src/rtls_pkg.sv
// Shared constants, types and op codes of the round-trip latency monitor.
package rtls_pkg;

  // Field widths of the transfers
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TS_W      = 48;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned RTT_W     = 32;
  localparam int unsigned AVG_W     = 36;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned FRAC_W    = 4;

  // Sample ring geometry
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);

  // 9*avg + 16*rtt fits in this many bits
  localparam int unsigned SUM_W = 40;

  // Register stages of the divide-by-ten unit, and of the whole item pipeline
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned PIPE_N     = DIV_STAGES + 1;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_RECORD = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic               rec;    // record with a pending start
    logic               ign;    // record with nothing pending
    logic               rd;     // read of a slot inside the ring
    logic               first;  // average unset when the record was taken
    logic [RING_AW-1:0] idx;
    logic [RTT_W-1:0]   rtt;
  } stage_t;

endpackage

>>> src/rtls_if.sv
// Valid/ready channel interfaces for items and results.
interface rtls_req_if;
  import rtls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [TS_W-1:0]      timestamp_us;
  logic [IDX_W-1:0]     sample_index;

  modport source (output valid, output op, output timestamp_us, output sample_index,
                  input ready);
  modport sink   (input valid, input op, input timestamp_us, input sample_index,
                  output ready);
endinterface

interface rtls_rsp_if;
  import rtls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 record_ignored;
  logic [RTT_W-1:0]     rtt_us;
  logic [AVG_W-1:0]     average_q4;
  logic [RTT_W-1:0]     minimum_us;
  logic [RTT_W-1:0]     maximum_us;
  logic [CNT_OUT_W-1:0] stored_count;
  logic [RTT_W-1:0]     sample_value;

  modport source (output valid, output record_ignored, output rtt_us, output average_q4,
                  output minimum_us, output maximum_us, output stored_count,
                  output sample_value, input ready);
  modport sink   (input valid, input record_ignored, input rtt_us, input average_q4,
                  input minimum_us, input maximum_us, input stored_count,
                  input sample_value, output ready);
endinterface

>>> src/rtls_div10.sv
// Pipelined unsigned divide by ten (shift-add reciprocal estimate plus one correction).
module rtls_div10 (
  input  logic                           clk_i,
  input  logic [rtls_pkg::DIV_STAGES-1:0] en_i,
  input  logic [rtls_pkg::SUM_W-1:0]     x_i,
  output logic [rtls_pkg::SUM_W-1:0]     q_o
);
  import rtls_pkg::*;

  localparam logic [SUM_W-1:0] TEN_M1 = SUM_W'(9);

  logic [SUM_W-1:0] x1_q, x2_q, x3_q, x4_q;
  logic [SUM_W-1:0] q2_q, q3_q, q4_q, q5_q;
  logic [SUM_W-1:0] r5_q;
  logic [SUM_W-1:0] q1, q2_d, t3, q3_d, q4_d, r5_d;

  // Estimate quotient: x * 0.8 refined by doubling shifts, then divided by eight
  always_comb begin
    q1   = (x1_q >> 1) + (x1_q >> 2);
    q2_d = q1 + (q1 >> 4);
    t3   = q2_q + (q2_q >> 8);
    q3_d = t3 + (t3 >> 16);
    q4_d = (q3_q + (q3_q >> 32)) >> 3;
    r5_d = x4_q - ((q4_q << 3) + (q4_q << 1));
  end

  // Advance each stage when the pipeline above it lets it
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q <= x_i;
    end
    if (en_i[1]) begin
      x2_q <= x1_q;
      q2_q <= q2_d;
    end
    if (en_i[2]) begin
      x3_q <= x2_q;
      q3_q <= q3_d;
    end
    if (en_i[3]) begin
      x4_q <= x3_q;
      q4_q <= q4_d;
    end
    if (en_i[4]) begin
      q5_q <= q4_q;
      r5_q <= r5_d;
    end
  end

  // Correct the estimate by one where the remainder reaches ten
  assign q_o = (r5_q > TEN_M1) ? q5_q + SUM_W'(1) : q5_q;

endmodule

>>> src/round_trip_latency_stats.sv
// Round-trip latency monitor: moving average, session min/max and a ring of samples.
//
//   channel | dir | transfer when      | payload
//   req_i   | in  | valid && ready     | op, timestamp_us, sample_index
//   rsp_o   | out | valid && ready     | record_ignored, rtt_us, average_q4, minimum_us,
//           |     |                    | maximum_us, stored_count, sample_value
//
// Each item passes through the PIPE_N pipeline stages and then the output register.
// Start and read items enter one per cycle while the pipeline is not stalled; a record
// waits at the input while an earlier measured record is still in the pipeline, so a
// record is taken only once the one before it has committed its average.
// Reset clears the pending start, the statistics, the ring pointer and fill count;
// the ring contents are left as they are. Stages collapse bubbles under output stall.
module round_trip_latency_stats (
  input logic clk_i,
  input logic rst_ni,
  rtls_req_if.sink   req_i,
  rtls_rsp_if.source rsp_o
);
  import rtls_pkg::*;

  // Architectural state
  logic [TS_W-1:0]    pending_q;
  logic [AVG_W-1:0]   avg_q;
  logic [RTT_W-1:0]   min_q, max_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RING_AW-1:0] wslot_q;
  logic [RTT_W-1:0]   ring_mem [RING_DEPTH];

  // Pipeline
  stage_t             s_q [1:PIPE_N];
  logic [PIPE_N:1]    v_q;
  logic [PIPE_N:1]    ld;
  logic               ld_out;
  stage_t             s_in;
  logic               acc, rec_in, rec_busy;
  logic [TS_W-1:0]    diff;
  logic [SUM_W-1:0]   sum_x, quot;
  logic [RTT_W-1:0]   rd_data_q, fwd_data_q;
  logic               fwd_q;

  // Output register
  logic               ov_q;
  logic               o_ign_q;
  logic [RTT_W-1:0]   o_rtt_q, o_min_q, o_max_q, o_smp_q;
  logic [AVG_W-1:0]   o_avg_q;
  logic [CNT_W-1:0]   o_cnt_q;

  // Final-stage updates
  stage_t             s_end;
  logic               wr_en;
  logic [AVG_W-1:0]   new_avg;
  logic [RTT_W-1:0]   new_min, new_max, smp_d;
  logic [CNT_W-1:0]   new_cnt;
  logic [RING_AW-1:0] new_wslot;

  // Load enables: a stage loads when it is empty or moving on
  always_comb begin
    ld_out     = !ov_q || rsp_o.ready;
    ld[PIPE_N] = !v_q[PIPE_N] || ld_out;
    for (int k = PIPE_N - 1; k >= 1; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  // Hold a record back while an earlier one is still updating the average
  always_comb begin
    rec_busy = 1'b0;
    for (int k = 1; k <= PIPE_N; k++) begin
      rec_busy = rec_busy | (v_q[k] & s_q[k].rec);
    end
  end

  assign rec_in      = (req_i.op == OP_RECORD);
  assign req_i.ready = ld[1] && !(rec_in && rec_busy);
  assign acc         = req_i.valid && req_i.ready;

  // Measure round trip against the pending start, clamp to 32 bits
  always_comb begin
    diff = (req_i.timestamp_us > pending_q) ? req_i.timestamp_us - pending_q : '0;
    s_in.rtt   = (|diff[TS_W-1:RTT_W]) ? '1 : diff[RTT_W-1:0];
    s_in.rec   = rec_in && (pending_q != '0);
    s_in.ign   = rec_in && (pending_q == '0);
    s_in.rd    = (req_i.op == OP_READ) && (int'(req_i.sample_index) < RING_DEPTH);
    s_in.first = (avg_q == '0);
    s_in.idx   = RING_AW'(req_i.sample_index);
  end

  // Pending start: set by a start, cleared by a measured record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (acc && (req_i.op == OP_START)) begin
      pending_q <= req_i.timestamp_us;
    end else if (acc && s_in.rec) begin
      pending_q <= '0;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[1]) begin
        v_q[1] <= acc;
      end
      for (int k = 2; k <= PIPE_N; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s_q[1] <= s_in;
    end
    for (int k = 2; k <= PIPE_N; k++) begin
      if (ld[k]) begin
        s_q[k] <= s_q[k-1];
      end
    end
  end

  // Weighted sum 9*avg + 16*rtt; average is stable while a record is in flight
  assign sum_x = (SUM_W'(avg_q) << 3) + SUM_W'(avg_q)
               + (SUM_W'(s_q[1].rtt) << FRAC_W);

  rtls_div10 u_div10 (
    .clk_i (clk_i),
    .en_i  (ld[PIPE_N:2]),
    .x_i   (sum_x),
    .q_o   (quot)
  );

  assign s_end = s_q[PIPE_N];
  assign wr_en = v_q[PIPE_N] && ld_out && s_end.rec;

  // Read the ring as an item enters the last stage; forward a write to the same slot
  always_ff @(posedge clk_i) begin
    if (ld[PIPE_N]) begin
      rd_data_q  <= ring_mem[s_q[PIPE_N-1].idx];
      fwd_q      <= wr_en && (wslot_q == s_q[PIPE_N-1].idx);
      fwd_data_q <= s_end.rtt;
    end
  end

  // Write the sample into the ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wslot_q] <= s_end.rtt;
    end
  end

  // Work out the statistics after this record
  always_comb begin
    new_avg   = s_end.first ? {s_end.rtt, {FRAC_W{1'b0}}} : AVG_W'(quot);
    new_min   = ((min_q == '0) || (s_end.rtt < min_q)) ? s_end.rtt : min_q;
    new_max   = (s_end.rtt > max_q) ? s_end.rtt : max_q;
    new_cnt   = (cnt_q < CNT_W'(RING_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;
    new_wslot = (wslot_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wslot_q + RING_AW'(1);
    smp_d     = s_end.rd ? (fwd_q ? fwd_data_q : rd_data_q) : '0;
  end

  // Commit statistics as a record leaves the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      cnt_q   <= '0;
      wslot_q <= '0;
    end else if (wr_en) begin
      avg_q   <= new_avg;
      min_q   <= new_min;
      max_q   <= new_max;
      cnt_q   <= new_cnt;
      wslot_q <= new_wslot;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_out) begin
      ov_q <= v_q[PIPE_N];
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (ld_out && v_q[PIPE_N]) begin
      o_ign_q <= s_end.ign;
      o_rtt_q <= s_end.rec ? s_end.rtt : '0;
      o_avg_q <= s_end.rec ? new_avg : avg_q;
      o_min_q <= s_end.rec ? new_min : min_q;
      o_max_q <= s_end.rec ? new_max : max_q;
      o_cnt_q <= s_end.rec ? new_cnt : cnt_q;
      o_smp_q <= smp_d;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.record_ignored = o_ign_q;
  assign rsp_o.rtt_us         = o_rtt_q;
  assign rsp_o.average_q4     = o_avg_q;
  assign rsp_o.minimum_us     = o_min_q;
  assign rsp_o.maximum_us     = o_max_q;
  assign rsp_o.stored_count   = CNT_OUT_W'(o_cnt_q);
  assign rsp_o.sample_value   = o_smp_q;

endmodule

>>> tb/sv/round_trip_latency_stats_tb.sv
// Self-checking testbench for the round-trip latency monitor, with its own statistics model.
`timescale 1ns / 1ps

module round_trip_latency_stats_tb;
  import rtls_pkg::*;

  // Op code 3 is unused by the block: statistics are reported, nothing changes
  localparam logic [OP_W-1:0]  OP_SPARE     = 2'd3;
  localparam logic [RTT_W-1:0] RTT_MAX      = '1;
  localparam int unsigned      QUIET_LIMIT  = 2000;
  localparam int unsigned      HOLD_CYCLES  = 300;
  localparam int unsigned      DRAIN_CYCLES = 2 * (PIPE_N + 1);

  typedef struct packed {
    logic                 ignored;
    logic [RTT_W-1:0]     rtt;
    logic [AVG_W-1:0]     avg_q4;
    logic [RTT_W-1:0]     shortest;
    logic [RTT_W-1:0]     longest;
    logic [CNT_OUT_W-1:0] count;
    logic [RTT_W-1:0]     sample;
  } stats_t;

  logic clk_i;
  logic rst_ni;

  rtls_req_if req_if ();
  rtls_rsp_if rsp_if ();

  round_trip_latency_stats dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model state of the monitor
  logic [TS_W-1:0]    m_pending;
  logic [AVG_W-1:0]   m_avg;
  logic [RTT_W-1:0]   m_shortest;
  logic [RTT_W-1:0]   m_longest;
  logic [RTT_W-1:0]   m_ring [RING_DEPTH];
  logic [RING_AW-1:0] m_slot;
  logic [CNT_W-1:0]   m_fill;

  stats_t stats_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asks;
  int unsigned mismatches;
  int unsigned n_items, n_timed, n_ignored, n_reads, n_starts, n_spare, n_saturated, n_zero;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the statistics reported for one item and advance the model state
  function automatic stats_t predict_stats(input logic [OP_W-1:0] op,
                                           input logic [TS_W-1:0] ts,
                                           input logic [IDX_W-1:0] idx);
    stats_t          s;
    logic [TS_W-1:0] span;
    logic [63:0]     wide;
    s = '0;
    case (op)
      OP_START: begin
        m_pending = ts;
        n_starts++;
      end
      OP_RECORD: begin
        if (m_pending == '0) begin
          s.ignored = 1'b1;
          n_ignored++;
        end else begin
          span  = (ts > m_pending) ? ts - m_pending : '0;
          s.rtt = (span > TS_W'(RTT_MAX)) ? RTT_MAX : span[RTT_W-1:0];
          m_pending = '0;
          if (m_avg == '0) begin
            m_avg = AVG_W'(s.rtt) << FRAC_W;
          end else begin
            wide  = 64'(m_avg) * 64'd9 + (64'(s.rtt) << FRAC_W);
            m_avg = AVG_W'(wide / 64'd10);
          end
          if (m_shortest == '0 || s.rtt < m_shortest) m_shortest = s.rtt;
          if (s.rtt > m_longest) m_longest = s.rtt;
          m_ring[m_slot] = s.rtt;
          m_slot = m_slot + 1'b1;
          if (m_fill < RING_DEPTH) m_fill = m_fill + 1'b1;
          n_timed++;
          if (s.rtt == RTT_MAX) n_saturated++;
          if (s.rtt == '0) n_zero++;
        end
      end
      OP_READ: begin
        s.sample = m_ring[idx];
        n_reads++;
      end
      default: n_spare++;
    endcase
    s.avg_q4   = m_avg;
    s.shortest = m_shortest;
    s.longest  = m_longest;
    s.count    = CNT_OUT_W'(m_fill);
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Offer one item, wait for its transfer and log its expected statistics
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.timestamp_us <= ts;
    req_if.sample_index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    stats_due.push_back(predict_stats(op, ts, idx));
    n_items++;
  endtask

  function automatic logic [TS_W-1:0] rand_stamp();
    return TS_W'({$urandom, $urandom});
  endfunction

  // Distance from start to record: mostly short, some near and past saturation, some negative
  function automatic logic [TS_W-1:0] rand_span();
    case ($urandom_range(9))
      0, 1, 2, 3: return TS_W'($urandom_range(2000));
      4, 5:       return TS_W'($urandom_range(1 << 20));
      6:          return TS_W'($urandom);
      7:          return TS_W'(RTT_MAX) - 48'd2 + TS_W'($urandom_range(4));
      8:          return rand_stamp();
      default:    return -TS_W'($urandom_range(1, 100000));
    endcase
  endfunction

  // Mostly start/record pairs and reads of written slots, with some stray traffic
  task automatic random_traffic(input int unsigned wanted);
    int unsigned     sent;
    int unsigned     pick;
    logic [TS_W-1:0] t0;
    sent = 0;
    while (sent < wanted) begin
      pick = $urandom_range(99);
      t0   = rand_stamp();
      if (pick < 55) begin
        send_item(OP_START, t0, IDX_W'($urandom));
        send_item(OP_RECORD, t0 + rand_span(), IDX_W'($urandom));
        sent += 2;
      end else if (pick < 75) begin
        if (m_fill != '0) begin
          send_item(OP_READ, t0, IDX_W'($urandom_range(int'(m_fill) - 1)));
        end else begin
          send_item(OP_START, t0, IDX_W'($urandom));
        end
        sent++;
      end else if (pick < 82) begin
        send_item(OP_START, t0, IDX_W'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_item(OP_RECORD, t0, IDX_W'($urandom));
        sent++;
      end else if (pick < 95) begin
        send_item(OP_SPARE, t0, IDX_W'($urandom));
        sent++;
      end else begin
        send_item(OP_START, '0, IDX_W'($urandom));
        send_item(OP_RECORD, t0, IDX_W'($urandom));
        sent += 2;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 21;
    recv_idle_pct = 83;
    // records with nothing pending, unused op, start at time zero
    send_item(OP_RECORD, 48'd500, 6'd0);
    send_item(OP_SPARE, 48'hFFFF_FFFF_FFFF, 6'h3F);
    send_item(OP_START, 48'd0, 6'd0);
    send_item(OP_RECORD, 48'd100, 6'd0);
    // zero round trip while the average is unset, then a first real sample
    send_item(OP_START, 48'd7, 6'h3F);
    send_item(OP_RECORD, 48'd7, 6'd0);
    send_item(OP_START, 48'd100, 6'd0);
    send_item(OP_RECORD, 48'd150, 6'd0);
    // zero round trip with the average set, then time going backwards
    send_item(OP_START, 48'd1000, 6'd0);
    send_item(OP_RECORD, 48'd1000, 6'd0);
    send_item(OP_START, 48'd5000, 6'd0);
    send_item(OP_RECORD, 48'd4000, 6'd0);
    // saturation, alternating bits, top of the timestamp range, exact limit
    send_item(OP_START, 48'd1, 6'd0);
    send_item(OP_RECORD, 48'hFFFF_FFFF_FFFF, 6'd0);
    send_item(OP_START, 48'hAAAA_AAAA_AAAA, 6'h2A);
    send_item(OP_RECORD, 48'hAAAA_FFFF_FFFF, 6'h15);
    send_item(OP_START, 48'hFFFF_FFFF_FFFE, 6'd0);
    send_item(OP_RECORD, 48'hFFFF_FFFF_FFFF, 6'd0);
    send_item(OP_START, 48'h10, 6'd0);
    send_item(OP_RECORD, 48'h10 + 48'hFFFF_FFFF, 6'd0);
    // second record in a row has nothing pending
    send_item(OP_RECORD, 48'd200, 6'd0);
    // reads of written slots
    send_item(OP_READ, 48'd0, 6'd0);
    send_item(OP_READ, 48'd0, 6'd3);
    send_item(OP_READ, 48'd0, IDX_W'(int'(m_fill) - 1));
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 21;
    recv_idle_pct = 83;
    random_traffic(325);
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 83;
    recv_idle_pct = 21;
    random_traffic(325);
  endtask

  // Hold the result side off for a long stretch while items keep coming
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    random_traffic(60);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(325);
  endtask

  // Result side ready: random stalls, plus a long hold-off when asked
  initial begin : rsp_ready_drive
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expected statistics
  always @(posedge clk_i) begin : result_check
    stats_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (stats_due.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
      end else begin
        want = stats_due.pop_front();
        check_field("record_ignored", 64'(rsp_if.record_ignored), 64'(want.ignored));
        check_field("rtt_us", 64'(rsp_if.rtt_us), 64'(want.rtt));
        check_field("average_q4", 64'(rsp_if.average_q4), 64'(want.avg_q4));
        check_field("minimum_us", 64'(rsp_if.minimum_us), 64'(want.shortest));
        check_field("maximum_us", 64'(rsp_if.maximum_us), 64'(want.longest));
        check_field("stored_count", 64'(rsp_if.stored_count), 64'(want.count));
        check_field("sample_value", 64'(rsp_if.sample_value), 64'(want.sample));
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, stats_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.op           <= OP_START;
    req_if.timestamp_us <= '0;
    req_if.sample_index <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks     = 0;
    mismatches    = 0;
    m_pending  = '0;
    m_avg      = '0;
    m_shortest = '0;
    m_longest  = '0;
    m_slot     = '0;
    m_fill     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_slow_receiver();
    test_slow_sender();
    test_output_hold();
    test_full_rate();
    req_if.valid <= 1'b0;

    // drain outstanding results, then watch for stray ones
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items: %0d starts, %0d timed records, %0d ignored records,",
             n_items, n_starts, n_timed, n_ignored);
    $display("%0d reads, %0d unused ops, %0d saturated and %0d zero round trips, %0d mismatches",
             n_reads, n_spare, n_saturated, n_zero, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
